// ===== rtl/ggc_pkg.sv =====
package ggc_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int ROW_W        = 64;
  localparam int VTX_W        = 6;
  localparam int CNT_W        = 7;
  localparam int COLOR_W      = 6;
  localparam int NUM_COLORS   = 64;
  localparam int PAL_W        = 7;
  localparam int LANE_N       = 8;
  localparam int LANE_W       = 8;
  localparam int LANE_ID_W    = 3;
  localparam int LANE_J_W     = 3;

  localparam logic [PAL_W-1:0] PAL_RESET = 7'd64;

  typedef logic [COLOR_W-1:0]    color_t;
  typedef logic [NUM_COLORS-1:0] used_t;

  typedef struct packed {
    color_t color;
    logic   exceeds;
  } merge_res_t;

endpackage

// ===== rtl/greedy_graph_colorer.sv =====
// Greedy first-fit graph colorer. Each input word is the adjacency row of the
// next vertex (in_tuser high starts a new graph at vertex 0); the block answers
// with the vertex index and the lowest color that no earlier adjacent vertex
// holds, flagging colors at or above palette_size and rows beyond 64 vertices
// (such rows are dropped and report zeros). Each word passes first through
// eight parallel lanes that decode the stored colors of their eight vertices,
// then the merge, which ORs the lanes, picks the lowest free color and writes
// it back. A new word is taken while the previous result waits on out_tready,
// but a result that is not taken stalls the merge of the next word. No
// clearing pass follows reset; a start word only clears the vertex counter.
module greedy_graph_colorer
  import ggc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata,   // [6:0] palette_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // [63:0] adjacency_row
  input  logic        in_tuser,    // [0] start_graph
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [5:0] vertex_index, [11:6] assigned_color
  output logic [1:0]  out_tuser    // [0] exceeds_palette, [1] capacity_overflow
);

  typedef enum logic [1:0] {ST_IDLE, ST_LANE, ST_MERGE} phase_t;

  phase_t             phase_r;
  logic [PAL_W-1:0]   palette_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [ROW_W-1:0]   row_r;
  color_t             store_r [MAX_VERTICES];
  used_t              lane_used [LANE_N];
  merge_res_t         mres;
  logic               out_valid_r;
  logic [VTX_W-1:0]   out_vtx_r;
  color_t             out_color_r;
  logic               out_exc_r;
  logic               out_ovf_r;

  logic in_acc;
  logic finish;
  logic overflow;

  assign cfg_tready = 1'b1;
  assign finish     = (phase_r == ST_MERGE) && (!out_valid_r || out_tready);
  assign in_tready  = (phase_r == ST_IDLE) || finish;
  assign in_acc     = in_tvalid && in_tready;
  assign overflow   = (cnt_r >= CNT_W'(MAX_VERTICES));

  genvar g;
  generate
    for (g = 0; g < LANE_N; g++) begin : g_lane
      ggc_lane u_lane (
        .clk      (clk),
        .ld       (phase_r == ST_LANE),
        .lane_id  (LANE_ID_W'(g)),
        .vtx_cnt  (cnt_r),
        .row_bits (row_r[g*LANE_W +: LANE_W]),
        .colors   (store_r[g*LANE_W +: LANE_W]),
        .used_r   (lane_used[g])
      );
    end
  endgenerate

  ggc_merge u_merge (
    .lane_used (lane_used),
    .palette   (palette_r),
    .res       (mres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ST_IDLE;
      palette_r   <= PAL_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_tvalid && cfg_tready) begin
        palette_r <= cfg_tdata[PAL_W-1:0];
      end

      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      // advance the counter on a colored vertex; a start word overrides it
      if (in_acc && in_tuser) begin
        cnt_r <= '0;
      end else if (finish && !overflow) begin
        cnt_r <= cnt_r + 1'b1;
      end

      case (phase_r)
        ST_IDLE: begin
          if (in_acc) begin
            phase_r <= ST_LANE;
          end
        end
        ST_LANE: begin
          phase_r <= ST_MERGE;
        end
        ST_MERGE: begin
          if (in_acc) begin
            phase_r <= ST_LANE;
          end else if (finish) begin
            phase_r <= ST_IDLE;
          end
        end
        default: begin
          phase_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_r <= in_tdata;
    end
    if (finish) begin
      if (overflow) begin
        out_vtx_r   <= '0;
        out_color_r <= '0;
        out_exc_r   <= 1'b0;
        out_ovf_r   <= 1'b1;
      end else begin
        store_r[cnt_r[VTX_W-1:0]] <= mres.color;
        out_vtx_r   <= cnt_r[VTX_W-1:0];
        out_color_r <= mres.color;
        out_exc_r   <= mres.exceeds;
        out_ovf_r   <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_color_r, out_vtx_r};
  assign out_tuser  = {out_ovf_r, out_exc_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex counter past capacity");

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata == 16'd0 && !out_tuser[0]))
    else $error("overflow result carries nonzero fields");

  a_vtx0_color0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[1] && out_tdata[5:0] == 6'd0) |-> out_tdata[11:6] == 6'd0)
    else $error("vertex 0 not given color 0");

  a_result_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(phase_r == ST_MERGE))
    else $error("result raised outside merge");

endmodule

// ===== rtl/ggc_lane.sv =====
module ggc_lane
  import ggc_pkg::*;
(
  input  logic                 clk,
  input  logic                 ld,
  input  logic [LANE_ID_W-1:0] lane_id,
  input  logic [CNT_W-1:0]     vtx_cnt,
  input  logic [LANE_W-1:0]    row_bits,
  input  color_t               colors [LANE_W],
  output used_t                used_r
);

  used_t used_nxt;

  // OR the one-hot colors of the earlier neighbors that fall in this lane
  always_comb begin
    logic [CNT_W-1:0] idx;
    used_nxt = '0;
    for (int j = 0; j < LANE_W; j++) begin
      idx = {1'b0, lane_id, LANE_J_W'(j)};
      if (row_bits[j] && (idx < vtx_cnt)) begin
        used_nxt[colors[j]] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      used_r <= used_nxt;
    end
  end

endmodule

// ===== rtl/ggc_merge.sv =====
module ggc_merge
  import ggc_pkg::*;
(
  input  used_t            lane_used [LANE_N],
  input  logic [PAL_W-1:0] palette,
  output merge_res_t       res
);

  used_t  used_all;
  color_t color;

  always_comb begin
    used_all = '0;
    for (int k = 0; k < LANE_N; k++) begin
      used_all = used_all | lane_used[k];
    end
  end

  // lowest free color; the top color is taken when all below it are used
  always_comb begin
    color = color_t'(NUM_COLORS - 1);
    for (int i = NUM_COLORS - 2; i >= 0; i--) begin
      if (!used_all[i]) begin
        color = color_t'(i);
      end
    end
  end

  assign res.color   = color;
  assign res.exceeds = ({1'b0, color} >= palette);

endmodule
